// File: design/kmp_pkg.sv
package kmp_pkg;
  localparam int CMD_W = 1;
  localparam int IDX_W = 6;
  localparam int LEN_W = 7;
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEXT = 1'b1;

  typedef struct packed {
    logic start;
    logic [LEN_W-1:0] dividend;
    logic [LEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic exact;
    logic [LEN_W-1:0] quotient;
  } div_rsp_t;
endpackage

// File: design/kmp_div.sv
module kmp_div (
  input  logic             clk,
  input  logic             rst_n,
  input  kmp_pkg::div_req_t req,
  output kmp_pkg::div_rsp_t rsp
);
  import kmp_pkg::*;

  logic [LEN_W-1:0] rem_r, rem_nxt, quo_r, quo_nxt, dvs_r, dvs_nxt, dvd_r, dvd_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [LEN_W:0] trial;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    dvs_nxt = dvs_r;
    dvd_nxt = dvd_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r, dvd_r[LEN_W-1]};
    if (req.start) begin
      rem_nxt = '0;
      quo_nxt = '0;
      dvs_nxt = req.divisor;
      dvd_nxt = req.dividend;
      cnt_nxt = 3'(LEN_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[LEN_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = LEN_W'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[LEN_W-2:0], 1'b1};
      end else begin
        rem_nxt = LEN_W'(trial);
        quo_nxt = {quo_r[LEN_W-2:0], 1'b0};
      end
      if (cnt_r == 3'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    dvd_r <= dvd_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.exact = (rem_r == '0) && (dvs_r != '0);
  assign rsp.quotient = quo_r;
endmodule

// File: design/kmp_stream_matcher.sv
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_ready   | command, symbol, pattern_index, restart, ...
// out     | output    | out_valid / out_ready | kind, match_found, match_start, ...
// cfg     | input     | cfg_we                | cfg_pattern_length
// one transaction at a time; a text symbol reads the entries at j and then compares,
// plus a read and compare per failure-chain step (a fall to minus one skips the read)
// and a failure read on a match; a pattern load takes the same walk (no first read at index
// zero), then a failure read, the divider start and the wait in the iterative divider
// the memory read port (one read per cycle, registered data) sets the walk rate
// rst_n is synchronous active low; failure entry zero is a constant minus one, not in memory
// out stall holds the result register; the next transaction is accepted once it is taken
module kmp_stream_matcher #(
  parameter int MAX_PATTERN = 64,
  parameter int SYMBOL_WIDTH = 8,
  parameter int POSITION_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [0:0]  in_command,
  input  logic [7:0]  in_symbol,
  input  logic [5:0]  in_pattern_index,
  input  logic        in_restart,
  input  logic [31:0] in_start_index,
  input  logic        in_last_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [0:0]  out_kind,
  output logic        out_match_found,
  output logic [31:0] out_match_start,
  output logic        out_no_match_in_text,
  output logic [6:0]  out_prefix_repeat_count,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_pattern_length
);
  import kmp_pkg::*;

  localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN + 1) : 1;
  localparam int BW = AW + 1; // signed border, minus one allowed
  localparam int PW = POSITION_WIDTH;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_CMP  = 6'b000100,
    S_DIV  = 6'b001000,
    S_WAIT = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // memories: pattern symbols and failure entries, registered read data
  logic [SYMBOL_WIDTH-1:0] pat_mem [MAX_PATTERN];
  logic [BW-1:0] fail_mem [MAX_PATTERN+1];
  logic [SYMBOL_WIDTH-1:0] pat_q;
  logic [BW-1:0] fail_q;
  logic [AW-1:0] rd_addr;
  logic pat_we, fail_we;
  logic [AW-1:0] pat_wa, fail_wa;
  logic [BW-1:0] fail_wd;

  always_ff @(posedge clk) begin
    if (pat_we) pat_mem[pat_wa[$clog2(MAX_PATTERN > 1 ? MAX_PATTERN : 2)-1:0]] <=
        SYMBOL_WIDTH'(in_symbol);
    if (fail_we) fail_mem[fail_wa] <= fail_wd;
    pat_q <= pat_mem[rd_addr[$clog2(MAX_PATTERN > 1 ? MAX_PATTERN : 2)-1:0]];
    fail_q <= fail_mem[rd_addr];
  end

  logic [SYMBOL_WIDTH-1:0] in_sym_r;
  logic cmd_r, last_r;
  logic [BW-1:0] j_r, j_nxt, build_r, build_nxt, mb_r, mb_nxt;
  logic [AW-1:0] loaded_r, loaded_nxt, m_eff;
  logic [6:0] len_r;
  logic [PW-1:0] pos_r, pos_nxt;
  logic seen_r, seen_nxt, res_match_nxt, res_nm_nxt, final_r, final_nxt;
  logic [PW-1:0] res_start_nxt;
  logic [6:0] res_cnt_nxt;
  logic res_match_r, res_nm_r;
  logic [PW-1:0] res_start_r;
  logic [6:0] res_cnt_r;
  div_req_t dreq;
  div_rsp_t drsp;

  kmp_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  always_comb begin
    if (len_r == 7'd0) m_eff = AW'(1);
    else if ({25'd0, len_r} > MAX_PATTERN) m_eff = AW'(MAX_PATTERN);
    else m_eff = AW'(len_r);
  end

  logic j_neg;
  logic [AW-1:0] j_plus1, idx_in;
  assign j_neg = j_r[BW-1];
  assign j_plus1 = AW'(j_r + 1'b1);
  assign idx_in = AW'(in_pattern_index);

  always_comb begin
    state_nxt = state_r;
    j_nxt = j_r;
    build_nxt = build_r;
    mb_nxt = mb_r;
    loaded_nxt = loaded_r;
    pos_nxt = pos_r;
    seen_nxt = seen_r;
    final_nxt = final_r;
    res_match_nxt = res_match_r;
    res_nm_nxt = res_nm_r;
    res_start_nxt = res_start_r;
    res_cnt_nxt = res_cnt_r;
    rd_addr = j_r[AW-1:0];
    pat_we = 1'b0;
    pat_wa = loaded_r;
    fail_we = 1'b0;
    fail_wa = loaded_r;
    fail_wd = j_r;
    dreq = '0;
    dreq.dividend = len_r;
    dreq.divisor = 7'(len_r - 7'(fail_q));
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_match_nxt = 1'b0;
          res_nm_nxt = 1'b0;
          res_start_nxt = '0;
          res_cnt_nxt = '0;
          if (in_command == CMD_LOAD) begin
            if (int'(in_pattern_index) < MAX_PATTERN &&
                (in_pattern_index == 6'd0 || idx_in == loaded_r)) begin
              // failure entry zero is minus one and is never read from memory
              j_nxt = (in_pattern_index == 6'd0) ? '1 : build_r;
              loaded_nxt = idx_in;
              pat_we = 1'b1;
              pat_wa = idx_in;
              state_nxt = j_nxt[BW-1] ? S_CMP : S_READ;
              final_nxt = 1'b0;
            end else begin
              // ignored load: report the current prefix count
              final_nxt = 1'b1;
              j_nxt = BW'(loaded_r);
              state_nxt = (loaded_r == '0) ? S_OUT : S_READ;
              if (loaded_r == '0) res_cnt_nxt = 7'd1;
            end
          end else begin
            pos_nxt = in_restart ? PW'(in_start_index) : pos_r;
            if (in_restart) seen_nxt = 1'b0;
            j_nxt = (in_restart || mb_r[BW-1] || mb_r[AW-1:0] >= m_eff) ? '0 : mb_r;
            final_nxt = 1'b0;
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        rd_addr = final_r ? j_r[AW-1:0] : j_r[AW-1:0];
        state_nxt = final_r ? S_DIV : S_CMP;
      end
      S_CMP: begin
        // pat_q and fail_q belong to index j_r (unless j is minus one)
        if (!j_neg && pat_q != in_sym_r) begin
          j_nxt = (j_r == '0) ? '1 : fail_q;
          if (j_r == '0) state_nxt = S_CMP;
          else begin
            rd_addr = fail_q[AW-1:0];
            state_nxt = S_READ;
          end
        end else if (cmd_r == CMD_LOAD) begin
          fail_we = 1'b1;
          fail_wa = AW'(loaded_r + 1'b1);
          fail_wd = BW'(j_plus1);
          build_nxt = BW'(j_plus1);
          loaded_nxt = AW'(loaded_r + 1'b1);
          final_nxt = 1'b1;
          j_nxt = BW'(AW'(loaded_r + 1'b1));
          state_nxt = S_READ;
        end else begin
          if (j_plus1 == m_eff) begin
            res_match_nxt = 1'b1;
            res_start_nxt = PW'(pos_r + 1'b1 - PW'(m_eff));
            seen_nxt = 1'b1;
            j_nxt = BW'(m_eff);
            final_nxt = 1'b1;
            state_nxt = S_READ;
          end else begin
            mb_nxt = BW'(j_plus1);
            pos_nxt = PW'(pos_r + 1'b1);
            res_nm_nxt = last_r && !seen_r;
            state_nxt = S_OUT;
          end
        end
      end
      S_DIV: begin
        if (cmd_r == CMD_TEXT) begin
          // fail_q is failure_table[m]
          mb_nxt = (fail_q[BW-1] || fail_q[AW-1:0] >= m_eff) ? '0 : fail_q;
          pos_nxt = PW'(pos_r + 1'b1);
          res_nm_nxt = 1'b0;
          state_nxt = S_OUT;
        end else begin
          dreq.start = 1'b1;
          dreq.dividend = 7'(j_r);
          dreq.divisor = 7'(j_r - fail_q);
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (drsp.done) begin
          res_cnt_nxt = drsp.exact ? drsp.quotient : 7'd1;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      build_r <= '1;
      loaded_r <= '0;
      mb_r <= '0;
      pos_r <= '0;
      seen_r <= 1'b0;
      len_r <= 7'd1;
    end else begin
      state_r <= state_nxt;
      build_r <= build_nxt;
      loaded_r <= loaded_nxt;
      mb_r <= mb_nxt;
      pos_r <= pos_nxt;
      seen_r <= seen_nxt;
      if (cfg_we) len_r <= cfg_pattern_length;
    end
    j_r <= j_nxt;
    final_r <= final_nxt;
    res_match_r <= res_match_nxt;
    res_nm_r <= res_nm_nxt;
    res_start_r <= res_start_nxt;
    res_cnt_r <= res_cnt_nxt;
    if (state_r == S_IDLE && in_valid) begin
      in_sym_r <= SYMBOL_WIDTH'(in_symbol);
      cmd_r <= in_command;
      last_r <= in_last_of_text;
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_kind = cmd_r;
  assign out_match_found = res_match_r;
  assign out_match_start = 32'(res_start_r);
  assign out_no_match_in_text = res_nm_r | (cmd_r == CMD_TEXT && res_match_r ? 1'b0 : 1'b0);
  assign out_prefix_repeat_count = res_cnt_r;

  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("out and in active together");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_match_found) |-> out_kind == CMD_TEXT) else $error("match on load");
endmodule

// File: bench/testbench.sv
module testbench;
  import kmp_pkg::*;

  localparam int PAT_DEPTH = 64;
  localparam int RANDOM_ITEMS = 550;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 200;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  // one expected result transaction
  typedef struct {
    logic [0:0] kind;
    logic       found;
    logic [31:0] start;
    logic       no_match;
    logic [6:0] repeat_cnt;
  } match_result_t;

  // one directed stimulus row: a register write or an input transaction
  typedef struct {
    row_kind_t  row;
    logic [6:0] len_value;
    logic [0:0] cmd;
    logic [7:0] sym;
    logic [5:0] idx;
    logic       rst;
    logic [31:0] start;
    logic       last;
    bit         typed;
    match_result_t want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [0:0] in_command;
  logic [7:0] in_symbol;
  logic [5:0] in_pattern_index;
  logic in_restart;
  logic [31:0] in_start_index;
  logic in_last_of_text;
  logic out_valid;
  logic out_ready;
  logic [0:0] out_kind;
  logic out_match_found;
  logic [31:0] out_match_start;
  logic out_no_match_in_text;
  logic [6:0] out_prefix_repeat_count;
  logic cfg_we;
  logic [6:0] cfg_pattern_length;

  // predictor state, mirrors the matcher
  logic [7:0] pat_mem [PAT_DEPTH];
  int         border_tab [PAT_DEPTH+1];
  int         build_j;
  int         load_count;
  int         scan_j;
  logic [31:0] text_pos;
  bit         hit_seen;
  logic [6:0] len_reg;
  int         written_depth;   // prefix of the stores written since reset

  match_result_t pending_results [$];
  stim_row_t     directed_rows [$];
  int  error_count;
  int  idle_cycles;
  int  items_sent;
  int  burst_left;
  int  ready_phase;

  kmp_stream_matcher DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_command(in_command),
    .in_symbol(in_symbol),
    .in_pattern_index(in_pattern_index),
    .in_restart(in_restart),
    .in_start_index(in_start_index),
    .in_last_of_text(in_last_of_text),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_kind(out_kind),
    .out_match_found(out_match_found),
    .out_match_start(out_match_start),
    .out_no_match_in_text(out_no_match_in_text),
    .out_prefix_repeat_count(out_prefix_repeat_count),
    .cfg_we(cfg_we),
    .cfg_pattern_length(cfg_pattern_length)
  );

  // 8 time unit clock
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // repetition count of the loaded prefix of length len
  function automatic logic [6:0] prefix_repeats(int len);
    int period;
    if (len == 0) return 7'd1;
    period = len - border_tab[len];
    if (period == 0 || (len % period) != 0) return 7'd1;
    return 7'(len / period);
  endfunction

  // advance the predictor by one accepted transaction
  function automatic match_result_t match_predict(logic [0:0] cmd, logic [7:0] sym,
      logic [5:0] idx, logic rst, logic [31:0] start, logic last);
    match_result_t r;
    int j;
    int m;
    logic [31:0] pos;
    r.kind = cmd;
    r.found = 1'b0;
    r.start = '0;
    r.no_match = 1'b0;
    r.repeat_cnt = '0;
    if (cmd == CMD_LOAD) begin
      if (idx == 0 || int'(idx) == load_count) begin
        if (idx == 0) begin
          build_j = -1;
          border_tab[0] = -1;
        end
        pat_mem[idx] = sym;
        j = build_j;
        while (j >= 0 && pat_mem[j] != sym) j = border_tab[j];
        j++;
        border_tab[idx+1] = j;
        build_j = j;
        load_count = idx + 1;
        if (load_count > written_depth) written_depth = load_count;
      end
      r.repeat_cnt = prefix_repeats(load_count);
      return r;
    end
    m = len_reg;
    if (m < 1) m = 1;
    if (m > PAT_DEPTH) m = PAT_DEPTH;
    if (rst) begin
      scan_j = 0;
      text_pos = start;
      hit_seen = 1'b0;
    end
    pos = text_pos;
    j = scan_j;
    if (j < 0 || j >= m) j = 0;
    while (j >= 0 && pat_mem[j] != sym) j = border_tab[j];
    j++;
    if (j == m) begin
      r.found = 1'b1;
      r.start = pos + 32'd1 - 32'(m);
      hit_seen = 1'b1;
      j = border_tab[m];
    end
    if (j < 0 || j >= m) j = 0;
    scan_j = j;
    text_pos = pos + 32'd1;
    if (last && !hit_seen) r.no_match = 1'b1;
    return r;
  endfunction

  // sender pacing: bursts of random length with random gaps between them
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 40) : $urandom_range(1, 10);
    gap = $urandom_range(1, 6);
    in_valid <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  // drive one transaction and hold it until accepted
  task automatic send_item(logic [0:0] cmd, logic [7:0] sym, logic [5:0] idx, logic rst,
      logic [31:0] start, logic last, output match_result_t predicted);
    in_valid <= 1'b1;
    in_command <= cmd;
    in_symbol <= sym;
    in_pattern_index <= idx;
    in_restart <= rst;
    in_start_index <= start;
    in_last_of_text <= last;
    do @(posedge clk); while (!in_ready);
    predicted = match_predict(cmd, sym, idx, rst, start, last);
    items_sent++;
  endtask

  task automatic send_checked(logic [0:0] cmd, logic [7:0] sym, logic [5:0] idx, logic rst,
      logic [31:0] start, logic last);
    match_result_t p;
    send_item(cmd, sym, idx, rst, start, last, p);
    pending_results.push_back(p);
    pace_sender();
  endtask

  // sender holds off until every result has drained
  task automatic wait_drained();
    if (in_valid) in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write, only while the matcher is idle
  task automatic write_length(logic [6:0] value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_pattern_length <= value;
    @(posedge clk);
    len_reg = value;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic match_result_t load_ans(logic [6:0] cnt);
    match_result_t r;
    r.kind = CMD_LOAD;
    r.found = 1'b0;
    r.start = '0;
    r.no_match = 1'b0;
    r.repeat_cnt = cnt;
    return r;
  endfunction

  task automatic add_cfg(logic [6:0] value);
    stim_row_t s;
    s = '{row: ROW_CFG, len_value: value, cmd: CMD_LOAD, sym: 0, idx: 0, rst: 0, start: 0,
          last: 0, typed: 0, want: load_ans(0)};
    directed_rows.push_back(s);
  endtask

  task automatic add_load(logic [7:0] sym, logic [5:0] idx, logic [6:0] cnt);
    stim_row_t s;
    s = '{row: ROW_ITEM, len_value: 0, cmd: CMD_LOAD, sym: sym, idx: idx, rst: 0, start: 0,
          last: 0, typed: 1, want: load_ans(cnt)};
    directed_rows.push_back(s);
  endtask

  task automatic add_text(logic [7:0] sym, logic rst, logic [31:0] start, logic last);
    stim_row_t s;
    s = '{row: ROW_ITEM, len_value: 0, cmd: CMD_TEXT, sym: sym, idx: 6'h3F, rst: rst,
          start: start, last: last, typed: 0, want: load_ans(0)};
    directed_rows.push_back(s);
  endtask

  // result checker with its own ready pattern: random stalls alternating with free stretches
  always @(posedge clk) begin
    match_result_t w;
    ready_phase <= ready_phase + 1;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (ready_phase[7:6] == 2'b01) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 4) != 0);
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result transaction with nothing expected");
          error_count++;
        end else begin
          w = pending_results.pop_front();
          if (out_kind !== w.kind) begin
            $error("kind: expected %0h actual %0h", w.kind, out_kind);
            error_count++;
          end
          if (out_match_found !== w.found) begin
            $error("match_found: expected %0h actual %0h", w.found, out_match_found);
            error_count++;
          end
          if (out_match_start !== w.start) begin
            $error("match_start: expected %0h actual %0h", w.start, out_match_start);
            error_count++;
          end
          if (out_no_match_in_text !== w.no_match) begin
            $error("no_match_in_text: expected %0h actual %0h", w.no_match,
                   out_no_match_in_text);
            error_count++;
          end
          if (out_prefix_repeat_count !== w.repeat_cnt) begin
            $error("prefix_repeat_count: expected %0d actual %0d", w.repeat_cnt,
                   out_prefix_repeat_count);
            error_count++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    match_result_t p;
    stim_row_t s;
    int plen;
    int ntext;
    int pick;
    int bad_idx;
    logic [7:0] sa;
    logic [7:0] sb;
    logic [7:0] tsym;
    logic [31:0] tstart;
    logic trst;
    logic tlast;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_LOAD;
    in_symbol = '0;
    in_pattern_index = '0;
    in_restart = 1'b0;
    in_start_index = '0;
    in_last_of_text = 1'b0;
    cfg_we = 1'b0;
    cfg_pattern_length = 7'd1;
    items_sent = 0;
    burst_left = 0;

    // predictor reset
    foreach (pat_mem[i]) pat_mem[i] = '0;
    foreach (border_tab[i]) border_tab[i] = 0;
    border_tab[0] = -1;
    build_j = -1;
    load_count = 0;
    scan_j = 0;
    text_pos = '0;
    hit_seen = 1'b0;
    len_reg = 7'd1;
    written_depth = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    add_load(8'hFF, 6'd7, 7'd1);          // out of order with nothing loaded
    add_cfg(7'd3);
    add_load(8'h00, 6'd0, 7'd1);
    add_load(8'h00, 6'd1, 7'd2);
    add_load(8'h00, 6'd2, 7'd3);
    add_load(8'hFF, 6'd5, 7'd3);          // out of order, ignored
    add_load(8'hAA, 6'd63, 7'd3);
    add_text(8'h00, 1'b1, 32'hFFFF_FFFE, 1'b0);  // positions wrap
    add_text(8'h00, 1'b0, 32'h0, 1'b0);
    add_text(8'h00, 1'b0, 32'h0, 1'b0);
    add_text(8'h00, 1'b0, 32'h0, 1'b0);          // overlapping match
    add_text(8'hFF, 1'b0, 32'h0, 1'b1);
    add_text(8'h00, 1'b0, 32'h0, 1'b1);          // continues past last mark
    add_text(8'h55, 1'b1, 32'h1234_5678, 1'b1);  // lone last symbol, no match
    add_load(8'hFF, 6'd0, 7'd1);
    add_load(8'h00, 6'd1, 7'd1);
    add_cfg(7'd1);
    add_text(8'hFF, 1'b1, 32'h0, 1'b1);
    add_cfg(7'd0);                               // zero acts as one
    add_text(8'h00, 1'b1, 32'hFFFF_FFFF, 1'b1);
    add_cfg(7'd3);                               // longer than current pattern
    add_text(8'hFF, 1'b1, 32'h0, 1'b0);
    add_text(8'h00, 1'b0, 32'h0, 1'b0);
    add_cfg(7'd1);                               // shrink with border past the length
    add_text(8'h00, 1'b0, 32'h0, 1'b1);

    foreach (directed_rows[i]) begin
      s = directed_rows[i];
      if (s.row == ROW_CFG) begin
        write_length(s.len_value);
      end else begin
        send_item(s.cmd, s.sym, s.idx, s.rst, s.start, s.last, p);
        pending_results.push_back(s.typed ? s.want : p);
        pace_sender();
      end
    end

    // random part: load a pattern, set the length, stream text
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      plen = ($urandom_range(0, 7) == 0) ? PAT_DEPTH : $urandom_range(1, 8);
      sa = $urandom;
      sb = ($urandom_range(0, 2) == 0) ? sa : 8'($urandom);
      for (int k = 0; k < plen; k++) begin
        send_checked(CMD_LOAD, $urandom_range(0, 1) ? sa : sb, 6'(k), $urandom,
                     $urandom, $urandom);
        if ($urandom_range(0, 15) == 0) begin
          bad_idx = $urandom_range(1, 63);
          if (bad_idx == load_count) bad_idx = bad_idx % 63 + 1;
          send_checked(CMD_LOAD, $urandom, 6'(bad_idx), $urandom, $urandom, $urandom);
        end
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) write_length(7'd0);
      else if (pick == 1 && written_depth == PAT_DEPTH) write_length(7'd127);
      else if (pick == 2) write_length(7'($urandom_range(1, written_depth)));
      else write_length(7'(plen));
      ntext = $urandom_range(10, 40);
      for (int t = 0; t < ntext; t++) begin
        trst = (t == 0) || ($urandom_range(0, 15) == 0);
        tstart = $urandom_range(0, 1) ? 32'($urandom) : 32'hFFFF_FFFF - $urandom_range(0, 40);
        tlast = (t == ntext - 1) || ($urandom_range(0, 19) == 0);
        tsym = ($urandom_range(0, 9) == 0) ? 8'($urandom) : ($urandom_range(0, 1) ? sa : sb);
        send_checked(CMD_TEXT, tsym, $urandom, trst, tstart, tlast);
        if ($urandom_range(0, 19) == 0) begin
          bad_idx = $urandom_range(1, 63);
          if (bad_idx == load_count) bad_idx = bad_idx % 63 + 1;
          send_checked(CMD_LOAD, $urandom, 6'(bad_idx), $urandom, $urandom, $urandom);
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
